[src/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [7:0] NEWLINE_CODE       = 8'd10;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // stream widths, whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CURSOR_W    = 11;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CALC   = 7'b0000100,
        ST_EXEC   = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

endpackage

[src/text_console_cell_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console engine: a ROWS x COLS grid of character/attribute cells in one
// synchronous RAM, a cursor, and scrolling.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A read of a cell or a write that does not
// scroll passes through the CALC, EXEC and DONE states from input beat to
// output beat; a write that runs past the last cell, or a newline on the last
// row, also moves the whole screen up one row through the single cell RAM
// port pair, one cell per cycle, in the SCROLL state. After reset the RAM is
// cleared one cell per cycle, in the CLEAR state, before the first input beat is taken;
// default_attr writes are taken at any time. Items are handled one at a time,
// and the next input beat is taken while a result still waits at the output.
module text_console_cell_writer_top #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    // default attribute register
    input  logic        default_attr_we,
    input  logic [7:0]  default_attr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], col[14:8], row[19:15], attribute[27:20], at_cursor[28]
    input  logic [tccw_pkg::IN_TDATA_W-1:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_pos[10:0], scrolled[11], cell_char[19:12], cell_attr[27:20]
    output logic [tccw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int TOTAL = COLS * ROWS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CLW   = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int EW    = (AW > tccw_pkg::CURSOR_W) ? AW : tccw_pkg::CURSOR_W;

    tccw_pkg::state_t state_reg, state_next;

    logic [7:0]     default_attr_reg;

    // cursor kept as index and as row/column
    logic [AW-1:0]  cursor_reg, cursor_next;
    logic [CLW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;

    // captured item
    logic           mode_reg;
    logic [7:0]     char_reg;
    logic [7:0]     attr_reg;
    logic [CLW-1:0] col_reg;
    logic [RW-1:0]  row_reg;

    // computed in CALC
    logic [AW-1:0]  addr_reg;
    logic [CLW-1:0] ncol_reg;
    logic [RW-1:0]  nrow_reg;
    logic           scroll_reg;

    logic [AW-1:0]  sweep_reg, sweep_next;

    // cell RAM and its registered write request
    logic [15:0]    cell_mem [TOTAL];
    logic [15:0]    rd_data_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en_reg, wr_en_next;
    logic [AW-1:0]  wr_addr_reg, wr_addr_next;
    logic [15:0]    wr_data_reg, wr_data_next;
    logic           wr_src_rd_reg, wr_src_rd_next;
    logic [15:0]    mem_wdata;

    logic           m_tvalid_reg;
    logic [tccw_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // input decode
    logic [7:0]     in_char;
    logic [6:0]     in_col;
    logic [4:0]     in_row;
    logic [7:0]     in_attr;
    logic           in_at_cursor;
    logic [CLW-1:0] sel_col;
    logic [RW-1:0]  sel_row;
    logic           in_accept;
    logic           out_free;

    logic [CLW-1:0] calc_ncol;
    logic [RW-1:0]  calc_nrow;
    logic           calc_scroll;
    logic [7:0]     wr_attr;
    logic [EW-1:0]  cursor_ext;
    logic [7:0]     res_char;
    logic [7:0]     res_attr;

    assign in_char      = s_tdata[7:0];
    assign in_col       = s_tdata[14:8];
    assign in_row       = s_tdata[19:15];
    assign in_attr      = s_tdata[27:20];
    assign in_at_cursor = s_tdata[28];

    assign s_tready  = (state_reg == tccw_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // target cell: cursor or clamped column and row
    always_comb
    begin
        if (in_at_cursor)
        begin
            sel_col = cur_col_reg;
            sel_row = cur_row_reg;
        end
        else
        begin
            if (32'(in_col) > COLS - 1)
                sel_col = CLW'(COLS - 1);
            else
                sel_col = CLW'(in_col);
            if (32'(in_row) > ROWS - 1)
                sel_row = RW'(ROWS - 1);
            else
                sel_row = RW'(in_row);
        end
    end

    // position after the write
    always_comb
    begin
        calc_ncol   = col_reg + CLW'(1);
        calc_nrow   = row_reg;
        calc_scroll = 1'b0;
        if (char_reg == tccw_pkg::NEWLINE_CODE || 32'(col_reg) == COLS - 1)
        begin
            calc_ncol = '0;
            if (32'(row_reg) == ROWS - 1)
                calc_scroll = 1'b1;
            else
                calc_nrow = row_reg + RW'(1);
        end
    end

    assign wr_attr = (attr_reg == 8'd0) ? default_attr_reg : attr_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        cursor_next    = cursor_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        wr_en_next     = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_data_next   = wr_data_reg;
        wr_src_rd_next = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = sweep_reg;
                wr_data_next = '0;
                sweep_next   = sweep_reg + AW'(1);
                if (sweep_reg == AW'(TOTAL - 1))
                begin
                    sweep_next = '0;
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = tccw_pkg::ST_CALC;
            end
            tccw_pkg::ST_CALC:
            begin
                state_next = tccw_pkg::ST_EXEC;
            end
            tccw_pkg::ST_EXEC:
            begin
                if (mode_reg == tccw_pkg::MODE_READ)
                begin
                    rd_en      = 1'b1;
                    state_next = tccw_pkg::ST_DONE;
                end
                else
                begin
                    if (char_reg != tccw_pkg::NEWLINE_CODE)
                    begin
                        wr_en_next   = 1'b1;
                        wr_addr_next = addr_reg;
                        wr_data_next = {wr_attr, char_reg};
                    end
                    cursor_next  = AW'(32'(nrow_reg) * COLS + 32'(ncol_reg));
                    cur_col_next = ncol_reg;
                    cur_row_next = nrow_reg;
                    state_next   = scroll_reg ? tccw_pkg::ST_SCROLL : tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_SCROLL:
            begin
                // read one row below, write it back in the following cycle
                wr_en_next   = 1'b1;
                wr_addr_next = sweep_reg;
                wr_data_next = '0;
                if (32'(sweep_reg) < TOTAL - COLS)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(32'(sweep_reg) + COLS);
                    wr_src_rd_next = 1'b1;
                end
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(TOTAL - 1))
                begin
                    sweep_next = '0;
                    state_next = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = tccw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    assign mem_wdata = wr_src_rd_reg ? rd_data_reg : wr_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
            cell_mem[wr_addr_reg] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tccw_pkg::ST_CLEAR;
            default_attr_reg <= tccw_pkg::DEFAULT_ATTR_RESET;
            cursor_reg       <= '0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            sweep_reg        <= '0;
            wr_en_reg        <= 1'b0;
            wr_src_rd_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sweep_reg     <= sweep_next;
            wr_en_reg     <= wr_en_next;
            wr_src_rd_reg <= wr_src_rd_next;
            if (default_attr_we)
                default_attr_reg <= default_attr_data;
            if (state_reg == tccw_pkg::ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign cursor_ext = EW'(cursor_reg);
    assign res_char   = (mode_reg == tccw_pkg::MODE_READ) ? rd_data_reg[7:0] : 8'd0;
    assign res_attr   = (mode_reg == tccw_pkg::MODE_READ) ? rd_data_reg[15:8] : 8'd0;

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        if (in_accept)
        begin
            mode_reg <= s_tuser;
            char_reg <= in_char;
            attr_reg <= in_attr;
            col_reg  <= sel_col;
            row_reg  <= sel_row;
        end
        if (state_reg == tccw_pkg::ST_CALC)
        begin
            addr_reg   <= AW'(32'(row_reg) * COLS + 32'(col_reg));
            ncol_reg   <= calc_ncol;
            nrow_reg   <= calc_nrow;
            scroll_reg <= calc_scroll;
        end
        if (state_reg == tccw_pkg::ST_DONE && out_free)
        begin
            m_tdata_reg <= {4'd0, res_attr, res_char,
                            (mode_reg == tccw_pkg::MODE_WRITE) && scroll_reg,
                            cursor_ext[tccw_pkg::CURSOR_W-1:0]};
        end
    end

endmodule
